[hw/rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the deque cells, the top level and the checker.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_REM_FRONT = 3'd2;
  localparam logic [2:0] MODE_REM_BACK  = 3'd3;
  localparam logic [2:0] MODE_LIST      = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [ValueW-1:0] value;
  } cdq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] element;
    logic                     last;
  } cdq_res_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] data;
  } cdq_link_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_ROTATE
  } cdq_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } cdq_state_e;

endpackage

[hw/rtl/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell
// One deque slot: holds a value and a valid flag, trades data with its
// neighbors on front pushes, front pops and rotation; back ops load or clear.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cdq_pkg::cdq_op_e           op_i,
  input  logic signed [31:0]         value_i,
  input  logic signed [31:0]         head_i,
  input  cdq_pkg::cdq_link_t         prev_i,
  input  cdq_pkg::cdq_link_t         next_i,
  output cdq_pkg::cdq_link_t         link_o,
  output logic signed [31:0]         tail_o
);
  import cdq_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] data_q, data_d;
  logic                     is_tail;

  assign is_tail = valid_q & ~next_i.valid;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (op_i)
      OP_PUSH_FRONT: begin
        valid_d = prev_i.valid;
        data_d  = prev_i.data;
      end
      OP_PUSH_BACK: begin
        if (!valid_q && prev_i.valid) begin
          valid_d = 1'b1;
          data_d  = value_i;
        end
      end
      OP_POP_FRONT: begin
        valid_d = next_i.valid;
        data_d  = next_i.data;
      end
      OP_POP_BACK: begin
        if (is_tail) valid_d = 1'b0;
      end
      OP_ROTATE: begin
        if (is_tail) data_d = head_i;
        else if (valid_q) data_d = next_i.data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o = '{valid: valid_q, data: data_q};
  assign tail_o = is_tail ? data_q : '0;

endmodule

[hw/rtl/circular_deque_engine.sv]
// ----------------------------------------------------------------------------
// circular_deque_engine
// Bounded double-ended queue of signed 32-bit values kept in a row of cells,
// front element in cell 0.
// ----------------------------------------------------------------------------
// results: insert, remove and empty list results strobe in the cycle after transfer
// list: elements pass the list state and result register; last strobes as busy falls
// insert and remove: one item per cycle while no list runs, busy stays low
// list: busy while elements remain, one element per cycle as the cell row rotates
// list of an empty queue: single empty result, no busy
// reset: asynchronous, queue empty, cell data left unwritten
module circular_deque_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_req_t req_i,
  output logic              res_valid_o,
  output cdq_pkg::cdq_res_t res_o
);
  import cdq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cdq_state_e               state_q, state_d;
  cdq_op_e                  op;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          remain_q, remain_d;
  logic                     res_valid_q, res_valid_d;
  cdq_res_t                 res_q, res_d;
  cdq_link_t                link [DEPTH];
  logic signed [ValueW-1:0] tail [DEPTH];
  logic signed [ValueW-1:0] tail_data;
  logic                     full, empty, accept;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_link_t prev, next;
    if (i == 0) begin : g_first
      assign prev = '{valid: 1'b1, data: req_i.value};
    end else begin : g_mid_prev
      assign prev = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next = '{valid: 1'b0, data: '0};
    end else begin : g_mid_next
      assign next = link[i+1];
    end
    cdq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .value_i(req_i.value),
      .head_i (link[0].data),
      .prev_i (prev),
      .next_i (next),
      .link_o (link[i]),
      .tail_o (tail[i])
    );
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) tail_data = tail_data | tail[i];
  end

  assign full   = link[DEPTH-1].valid;
  assign empty  = ~link[0].valid;
  assign busy   = (state_q == ST_LIST);
  assign accept = start & ~busy;

  always_comb begin
    state_d     = state_q;
    op          = OP_HOLD;
    count_d     = count_q;
    remain_d    = remain_q;
    res_valid_d = 1'b0;
    res_d       = '{status: STATUS_OK, element: '0, last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.mode)
            MODE_INS_FRONT, MODE_INS_BACK: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                if (req_i.mode == MODE_INS_FRONT) op = OP_PUSH_FRONT;
                else op = OP_PUSH_BACK;
                count_d = count_q + 1'b1;
              end
            end
            MODE_REM_FRONT, MODE_REM_BACK: begin
              res_valid_d = 1'b1;
              if (empty) begin
                res_d.status = STATUS_EMPTY;
              end else if (req_i.mode == MODE_REM_FRONT) begin
                op            = OP_POP_FRONT;
                count_d       = count_q - 1'b1;
                res_d.element = link[0].data;
              end else begin
                op            = OP_POP_BACK;
                count_d       = count_q - 1'b1;
                res_d.element = tail_data;
              end
            end
            MODE_LIST: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_EMPTY;
              end else begin
                state_d  = ST_LIST;
                remain_d = count_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        op            = OP_ROTATE;
        res_valid_d   = 1'b1;
        res_d.element = link[0].data;
        res_d.last    = (remain_q == CntW'(1));
        remain_d      = remain_q - 1'b1;
        if (remain_q == CntW'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque engine, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input cdq_pkg::cdq_req_t req_i,
  input logic              res_valid_o,
  input cdq_pkg::cdq_res_t res_o
);
  import cdq_pkg::*;

  logic single_op, bad_mode;

  assign single_op = start && !busy && (req_i.mode == MODE_INS_FRONT ||
                     req_i.mode == MODE_INS_BACK || req_i.mode == MODE_REM_FRONT ||
                     req_i.mode == MODE_REM_BACK);
  assign bad_mode  = start && !busy && !(single_op || req_i.mode == MODE_LIST);

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    single_op |=> res_valid_o && res_o.last)
    else $error("insert or remove transfer gave no final result");

  a_bad_mode_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_mode |=> !res_valid_o)
    else $error("undefined mode produced a result");

  a_list_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o)
    else $error("list cycle without a result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |-> res_o.element == '0 && res_o.last)
    else $error("error result carries data or is not final");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status == STATUS_OK || res_o.status == STATUS_EMPTY ||
                    res_o.status == STATUS_FULL)
    else $error("unknown status code");

endmodule

bind circular_deque_engine cdq_checker u_cdq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_i      (req_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

[verif/circular_deque_engine_tb.sv]
// ----------------------------------------------------------------------------
// circular_deque_engine_tb
// Self-checking bench for the bounded deque. A driver sends commands from a
// queue that an initial block fills with directed and random sequences. A
// shadow deque predicts every answer, and a monitor checks each result
// strobe in order against the predicted answers.
// ----------------------------------------------------------------------------
module circular_deque_engine_tb;

  import cdq_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned N_RANDOM   = 420;

  typedef struct {
    cdq_req_t    req;
    int unsigned idle;
  } stim_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  cdq_req_t req_i = '0;
  logic     res_valid_o;
  cdq_res_t res_o;

  stim_t       cmd_q[$];
  cdq_res_t    deque_results_q[$];
  int unsigned idle_left;
  int unsigned xfer_cnt;
  int unsigned cmd_total;
  int unsigned defined_cnt;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  bit          no_idle;

  // shadow deque
  logic signed [31:0] ring_mem [DEPTH];
  logic [5:0]         head_ptr;
  logic [6:0]         fill_cnt;

  circular_deque_engine #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void deque_step(cdq_req_t r);
    cdq_res_t   res;
    logic [5:0] pos;
    res      = '0;
    res.last = 1'b1;
    case (r.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (fill_cnt == DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          if (r.mode == MODE_INS_FRONT) begin
            head_ptr = head_ptr - 6'd1;
            ring_mem[head_ptr] = r.value;
          end else begin
            pos = head_ptr + fill_cnt[5:0];
            ring_mem[pos] = r.value;
          end
          fill_cnt   = fill_cnt + 7'd1;
          res.status = STATUS_OK;
        end
        deque_results_q.push_back(res);
      end
      MODE_REM_FRONT, MODE_REM_BACK: begin
        if (fill_cnt == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          if (r.mode == MODE_REM_FRONT) begin
            res.element = ring_mem[head_ptr];
            head_ptr    = head_ptr + 6'd1;
          end else begin
            pos         = head_ptr + fill_cnt[5:0] - 6'd1;
            res.element = ring_mem[pos];
          end
          fill_cnt   = fill_cnt - 7'd1;
          res.status = STATUS_OK;
        end
        deque_results_q.push_back(res);
      end
      MODE_LIST: begin
        if (fill_cnt == 0) begin
          res.status = STATUS_EMPTY;
          deque_results_q.push_back(res);
        end else begin
          for (int unsigned i = 0; i < fill_cnt; i++) begin
            pos         = head_ptr + i[5:0];
            res.status  = STATUS_OK;
            res.element = ring_mem[pos];
            res.last    = (i + 1 == fill_cnt);
            deque_results_q.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORT) $display("%0t: %s", $realtime, msg);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t it;
    if (!rst_ni) begin
      start     <= 1'b0;
      req_i     <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        deque_step(req_i);
        xfer_cnt++;
      end
      if (!start || !busy) begin
        if (idle_left != 0) begin
          start     <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (cmd_q.size() != 0) begin
          it = cmd_q.pop_front();
          start     <= 1'b1;
          req_i     <= it.req;
          idle_left <= it.idle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cdq_res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (deque_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d element=%0d last=%0b",
                                  res_o.status, res_o.element, res_o.last));
      end else begin
        want = deque_results_q.pop_front();
        if (res_o.status !== want.status || res_o.element !== want.element ||
            res_o.last !== want.last) begin
          report_mismatch($sformatf(
              {"result mismatch: expected status=%0d element=%0d last=%0b, ",
               "got status=%0d element=%0d last=%0b"},
              want.status, want.element, want.last,
              res_o.status, res_o.element, res_o.last));
        end
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_MAX) begin
        $display("circular_deque_engine regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_cmd(logic [2:0] mode, logic [31:0] value);
    stim_t it;
    it.req.mode  = mode;
    it.req.value = value;
    it.idle      = no_idle ? 0 : $urandom_range(0, 11);
    cmd_q.push_back(it);
    cmd_total++;
    if (mode <= MODE_LIST) defined_cnt++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned m;
    head_ptr     = '0;
    fill_cnt     = '0;
    xfer_cnt     = 0;
    cmd_total    = 0;
    defined_cnt  = 0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;

    // directed: empty answers, ignored modes, extremes, both ends
    add_cmd(MODE_LIST, 32'h0);
    add_cmd(MODE_REM_FRONT, 32'hffff_ffff);
    add_cmd(MODE_REM_BACK, 32'h0);
    add_cmd(3'd5, 32'hffff_ffff);
    add_cmd(3'd6, 32'h0);
    add_cmd(3'd7, 32'hffff_ffff);
    add_cmd(MODE_INS_FRONT, 32'h7fff_ffff);
    add_cmd(MODE_INS_BACK, 32'h8000_0000);
    add_cmd(MODE_INS_FRONT, 32'hffff_ffff);
    add_cmd(MODE_INS_BACK, 32'h0);
    add_cmd(MODE_LIST, 32'h0);
    add_cmd(MODE_REM_BACK, 32'h0);
    add_cmd(MODE_REM_FRONT, 32'h0);
    add_cmd(MODE_LIST, 32'h0);
    add_cmd(MODE_REM_FRONT, 32'h0);
    add_cmd(MODE_REM_BACK, 32'h0);
    add_cmd(MODE_REM_FRONT, 32'h0);
    add_cmd(MODE_INS_BACK, 32'h1);
    add_cmd(MODE_INS_FRONT, 32'hffff_fffe);
    add_cmd(MODE_REM_BACK, 32'h0);
    add_cmd(MODE_LIST, 32'h0);
    add_cmd(MODE_REM_FRONT, 32'h0);

    defined_cnt = 0;
    while (defined_cnt < N_RANDOM) begin
      kind    = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin
          // fill at least to full, usually past it
          n = $urandom_range(64, 72);
          repeat (n) add_cmd($urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT,
                             pick_value());
          add_cmd(MODE_LIST, $urandom());
        end
        1: begin
          // drain at least to empty, usually past it
          n = $urandom_range(64, 72);
          repeat (n) add_cmd($urandom_range(0, 1) ? MODE_REM_BACK : MODE_REM_FRONT,
                             $urandom());
          add_cmd(MODE_LIST, $urandom());
        end
        default: begin
          n = $urandom_range(10, 30);
          repeat (n) begin
            m = $urandom_range(0, 15);
            if (m < 12)       add_cmd(m[2:0] & 3'd3, pick_value());
            else if (m == 12) add_cmd(MODE_LIST, $urandom());
            else if (m == 13) add_cmd(3'($urandom_range(5, 7)), $urandom());
            else              add_cmd(m[0] ? MODE_INS_BACK : MODE_INS_FRONT, pick_value());
          end
        end
      endcase
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (xfer_cnt < cmd_total) @(posedge clk_i);
    while (deque_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && deque_results_q.size() == 0) begin
      $display("circular_deque_engine regression: pass");
    end else begin
      $display("circular_deque_engine regression: fail");
    end
    $finish;
  end

endmodule
